// ===== sv/hds_pkg.sv =====
package hds_pkg;

   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int DELIM_SLOTS_DEF = 64;

   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [2:0] OC_DECLINE  = 3'd0;
   localparam logic [2:0] OC_START    = 3'd1;
   localparam logic [2:0] OC_CLOSED   = 3'd2;
   localparam logic [2:0] OC_EOF_POP  = 3'd3;
   localparam logic [2:0] OC_EOF_KEEP = 3'd4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SKIP,
      PH_LT2,
      PH_OPTS,
      PH_WORD,
      PH_BODY_BEGIN,
      PH_BODY_NEWLINE,
      PH_BODY_LINE
   } phase_type;

   typedef struct packed {
      logic       eof;
      logic [7:0] ch;
      logic       new_call;
      logic       start_valid;
      logic       body_valid;
      logic       is_blank;
      logic       is_lt;
      logic       is_nl;
      logic       is_tab;
      logic       is_dash;
      logic       is_quote;
   } item_type;

   typedef struct packed {
      logic       emit;
      logic [2:0] outcome;
      logic       consumed;
      logic [5:0] word_length;
   } emit_type;

endpackage

// ===== sv/hds_front.sv =====
module hds_front
   import hds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_ch,
   input  logic       req_new_call,
   input  logic       req_start_valid,
   input  logic       req_body_valid,
   output logic       item_valid,
   input  logic       item_ready,
   output item_type   item
);

   item_type   slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   item_type   cls;
   logic       push, pop;

   always_comb begin
      cls.eof         = req_kind;
      cls.ch          = req_ch;
      cls.new_call    = req_new_call;
      cls.start_valid = req_start_valid;
      cls.body_valid  = req_body_valid;
      cls.is_tab      = (req_ch == CH_TAB);
      cls.is_blank    = (req_ch == CH_SPACE) || (req_ch == CH_TAB);
      cls.is_lt       = (req_ch == CH_LT);
      cls.is_nl       = (req_ch == CH_NL);
      cls.is_dash     = (req_ch == CH_DASH);
      cls.is_quote    = (req_ch == CH_SQUOTE) || (req_ch == CH_DQUOTE);
   end

   assign req_ready  = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= cls;
      end
   end

endmodule

// ===== sv/hds_back.sv =====
module hds_back
   import hds_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int DELIM_SLOTS = DELIM_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   output logic       item_ready,
   input  item_type   item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_outcome,
   output logic       rsp_consumed,
   output logic [3:0] rsp_pending_count,
   output logic [5:0] rsp_word_length
);

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = FW + 1;
   localparam int MW = $clog2(DELIM_SLOTS);
   localparam int AW = $clog2(QUEUE_DEPTH * DELIM_SLOTS);
   localparam int MEM_DEPTH = QUEUE_DEPTH * DELIM_SLOTS;

   phase_type       phase_ff, phase_in, nxt_phase;
   logic [QW-1:0]   head_ff, head_in, tail;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [MW-1:0]   mp_ff, mp_in;
   logic            lm_ff, lm_in;
   logic            lt_ff, lt_in;
   logic [7:0]      oq_ff, oq_in;
   logic            cb_ff, cb_in;

   logic [7:0]      delim_mem_ff [MEM_DEPTH];
   logic [MW-1:0]   len_ff [QUEUE_DEPTH];
   logic            indent_ff [QUEUE_DEPTH];
   logic [7:0]      rd0_ff, rd1_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   emit_type        rsp_ff, rsp_in;

   emit_type        act;
   logic            adv;
   logic            push, pop, wr_en, ind_wr, ind_val;
   logic [AW-1:0]   waddr, ra0, ra1;
   logic [SW-1:0]   tail_sum;

   function automatic logic [MW-1:0] w_mp_wr();
      return (phase_ff == PH_WORD && !item.new_call) ? mp_ff : '0;
   endfunction

   assign tail_sum = SW'(head_ff) + SW'(fill_ff);
   assign tail = (tail_sum >= SW'(QUEUE_DEPTH)) ? QW'(tail_sum - SW'(QUEUE_DEPTH))
                                                 : QW'(tail_sum);

   assign adv        = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_ready = adv;

   always_comb begin
      logic          w_step, w_end, w_entry, w_line, w_begin, w_cons;
      logic [MW-1:0] w_mp, mpv, m2;
      logic          lmv, ltv, cbv;
      logic [7:0]    bytev;
      phase_type     ph;
      w_step = 1'b0; w_end = 1'b0; w_entry = 1'b0; w_line = 1'b0;
      w_begin = 1'b0; w_cons = 1'b0; w_mp = '0; m2 = '0;
      mpv = '0; lmv = 1'b0; ltv = 1'b1; bytev = 8'd0;
      act = '0;
      nxt_phase = phase_ff;
      mp_in = mp_ff; lm_in = lm_ff; lt_in = lt_ff; oq_in = oq_ff;
      push = 1'b0; pop = 1'b0; wr_en = 1'b0; ind_wr = 1'b0; ind_val = 1'b0;
      cbv = item.new_call ? item.body_valid : cb_ff;
      cb_in = cbv;
      ph = item.new_call ? (item.start_valid ? PH_SKIP : PH_IDLE) : phase_ff;
      if (item.new_call && !item.start_valid) begin
         nxt_phase = PH_IDLE;
         w_entry = 1'b1;
      end else begin
         unique case (ph)
            PH_IDLE: ;
            PH_SKIP: begin
               if (!item.eof && item.is_blank) nxt_phase = PH_SKIP;
               else if (!item.eof && item.is_lt) nxt_phase = PH_LT2;
               else w_entry = 1'b1;
            end
            PH_LT2: begin
               if (!item.eof && item.is_lt) begin
                  if (fill_ff == FW'(QUEUE_DEPTH)) begin
                     nxt_phase = PH_BODY_BEGIN;
                  end else begin
                     ind_wr = 1'b1; ind_val = 1'b0;
                     oq_in = 8'd0; mp_in = '0;
                     nxt_phase = PH_OPTS;
                  end
               end else begin
                  w_entry = 1'b1;
               end
            end
            PH_OPTS: begin
               if (!item.eof && item.is_dash && mp_ff == '0) begin
                  ind_wr = 1'b1; ind_val = 1'b1;
                  mp_in = MW'(1);
               end else if (!item.eof && item.is_quote) begin
                  oq_in = item.ch; mp_in = '0;
                  nxt_phase = PH_WORD;
               end else begin
                  w_step = 1'b1; w_mp = '0;
               end
            end
            PH_WORD: begin
               w_step = 1'b1; w_mp = mp_ff;
            end
            PH_BODY_BEGIN: w_entry = 1'b1;
            PH_BODY_NEWLINE: begin
               if (item.eof) begin
                  pop = (fill_ff != '0);
                  act.emit = 1'b1; act.outcome = OC_EOF_POP;
               end else begin
                  w_line = 1'b1; w_begin = 1'b1;
               end
            end
            PH_BODY_LINE: w_line = 1'b1;
            default: ;
         endcase
      end
      if (w_step) begin
         if (item.eof || item.is_nl || item.is_blank) begin
            w_end = 1'b1; w_cons = 1'b0;
         end else if (oq_ff != 8'd0 && item.ch == oq_ff) begin
            w_end = 1'b1; w_cons = 1'b1;
         end else begin
            wr_en = 1'b1;
            m2 = w_mp + MW'(1);
            if (m2 >= MW'(DELIM_SLOTS - 1)) begin
               w_end = 1'b1; w_cons = 1'b1; w_mp = m2;
            end else begin
               mp_in = m2; nxt_phase = PH_WORD;
            end
         end
      end
      if (w_end) begin
         mp_in = w_mp;
         if (w_mp == '0) begin
            if (w_cons) nxt_phase = PH_BODY_BEGIN;
            else w_entry = 1'b1;
         end else begin
            push = 1'b1;
            act.emit = 1'b1; act.outcome = OC_START;
            act.consumed = w_cons; act.word_length = 6'(w_mp);
         end
      end
      if (w_entry) begin
         if (!cbv || fill_ff == '0 || item.eof) begin
            act.emit = 1'b1; act.outcome = OC_DECLINE;
         end else begin
            w_line = 1'b1; w_begin = 1'b1;
         end
      end
      if (w_line) begin
         mpv   = w_begin ? '0 : mp_ff;
         lmv   = w_begin ? 1'b0 : lm_ff;
         ltv   = w_begin ? 1'b1 : lt_ff;
         bytev = w_begin ? rd0_ff : rd1_ff;
         mp_in = mpv; lm_in = lmv; lt_in = ltv;
         nxt_phase = PH_BODY_LINE;
         if (item.eof || item.is_nl) begin
            if (!lmv && mpv == len_ff[head_ff]) begin
               pop = 1'b1;
               act.emit = 1'b1; act.outcome = OC_CLOSED;
            end else if (item.eof) begin
               act.emit = 1'b1; act.outcome = OC_EOF_KEEP;
            end else begin
               nxt_phase = PH_BODY_NEWLINE;
            end
         end else if (ltv && indent_ff[head_ff] && item.is_tab) begin
            lt_in = 1'b1;
         end else begin
            lt_in = 1'b0;
            if (mpv < len_ff[head_ff] && bytev == item.ch) mp_in = mpv + MW'(1);
            else lm_in = 1'b1;
         end
      end
   end

   always_comb begin
      phase_in = act.emit ? PH_IDLE : nxt_phase;
      head_in  = head_ff;
      fill_in  = fill_ff;
      if (adv && pop) begin
         head_in = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QW'(1);
         fill_in = fill_ff - FW'(1);
      end else if (adv && push) begin
         fill_in = fill_ff + FW'(1);
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = act.emit;
         if (act.emit) begin
            rsp_in = act;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign waddr = AW'(AW'(tail) * AW'(DELIM_SLOTS) + AW'(w_mp_wr()));
   assign ra0   = AW'(AW'(head_in) * AW'(DELIM_SLOTS));
   assign ra1   = AW'(AW'(head_in) * AW'(DELIM_SLOTS) + AW'(adv ? mp_in : mp_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         mp_ff        <= '0;
         lm_ff        <= 1'b0;
         lt_ff        <= 1'b1;
         oq_ff        <= 8'd0;
         cb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            phase_ff <= phase_in;
            mp_ff    <= mp_in;
            lm_ff    <= lm_in;
            lt_ff    <= lt_in;
            oq_ff    <= oq_in;
            cb_ff    <= cb_in;
         end
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (adv && wr_en) begin
         delim_mem_ff[waddr] <= item.ch;
      end
      rd0_ff <= (adv && wr_en && waddr == ra0) ? item.ch : delim_mem_ff[ra0];
      rd1_ff <= (adv && wr_en && waddr == ra1) ? item.ch : delim_mem_ff[ra1];
      if (adv && ind_wr) begin
         indent_ff[tail] <= ind_val;
      end
      if (adv && push) begin
         len_ff[tail] <= mp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = rsp_ff.outcome;
   assign rsp_consumed      = rsp_ff.consumed;
   assign rsp_pending_count = 4'(fill_ff);
   assign rsp_word_length   = rsp_ff.word_length;

endmodule

// ===== sv/heredoc_delimiter_scanner_core.sv =====
// Shell here-document lexer taking one character per cycle unless a held result stalls it.
// Input items pass through a two-entry classifier queue into the scanner, which keeps up
// to QUEUE_DEPTH pending delimiters of up to DELIM_SLOTS-1 bytes in a delimiter memory
// with registered reads; the body scan compares one delimiter byte per cycle, so the
// sustained rate is one item per clock while results are taken. A result is registered
// and presented in the cycle after the deciding item is accepted, and waits in an output
// register; while it waits the scanner holds, and further items collect in the two-entry
// queue. The memory needs no clearing pass; only pushed slots are ever read.
module heredoc_delimiter_scanner_core
   import hds_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int DELIM_SLOTS = DELIM_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_ch,
   input  logic       req_new_call,
   input  logic       req_start_valid,
   input  logic       req_body_valid,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_outcome,
   output logic       rsp_consumed,
   output logic [3:0] rsp_pending_count,
   output logic [5:0] rsp_word_length
);

   logic     item_valid, item_ready;
   item_type item;

   hds_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_ch, .req_new_call,
      .req_start_valid, .req_body_valid, .item_valid, .item_ready, .item
   );

   hds_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .DELIM_SLOTS(DELIM_SLOTS)) u_back (
      .clock, .reset, .item_valid, .item_ready, .item, .rsp_valid, .rsp_ready,
      .rsp_outcome, .rsp_consumed, .rsp_pending_count, .rsp_word_length
   );

   a_len_only_on_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != OC_START |-> rsp_word_length == 6'd0)
      else $error("word length on non-start result");

   a_decline_not_consumed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OC_DECLINE |-> !rsp_consumed)
      else $error("declined result marked consumed");

   a_outcome_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_outcome <= OC_EOF_KEEP)
      else $error("outcome out of range");

endmodule
